### rtl/sap_pkg.sv
package sap_pkg;

  // Store geometry
  localparam int NUM_BINS = 2048;
  localparam int ADDR_W   = $clog2(NUM_BINS);
  localparam int BIN_W    = 11;
  localparam int CMP_W    = ((ADDR_W > BIN_W) ? ADDR_W : BIN_W) + 1;

  // Field widths
  localparam int LEVEL_W = 16;
  localparam int ALPHA_W = 16;
  localparam int DECAY_W = 15;
  localparam int CMD_W   = 2;
  localparam int PROD_W  = 34;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input commands
  localparam logic [CMD_W-1:0] CMD_MID   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIDE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;

  // Reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd16384;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 15'd256;
  localparam logic [LEVEL_W-1:0] FLOOR_RESET = 16'h8800;  // -30720

  typedef enum logic [1:0] {
    KIND_MID,
    KIND_SIDE,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               in_range;
    logic [ADDR_W-1:0]  addr;
    logic [BIN_W-1:0]   bin;
    logic [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [DECAY_W-1:0] decay;
    logic [LEVEL_W-1:0] floor_lvl;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_WB
  } back_state_t;

endpackage

### rtl/sap_ram.sv
module sap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/sap_front.sv
module sap_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sap_pkg::CMD_W-1:0]    in_cmd,
  input  logic [sap_pkg::BIN_W-1:0]    in_bin_index,
  input  logic [sap_pkg::LEVEL_W-1:0]  in_level_db,
  input  logic                         sweeping,
  output logic                         q_valid,
  output sap_pkg::item_t               q_item,
  input  logic                         q_pop
);

  sap_pkg::item_t                   q_mem_r [sap_pkg::QUEUE_DEPTH];
  logic [sap_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sap_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sap_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             push;
  logic                             take;
  sap_pkg::kind_t                   kind;
  logic [sap_pkg::CMP_W-1:0]        bin_wide;
  sap_pkg::item_t                   new_item;

  assign in_stall = (cnt_r == sap_pkg::QCNT_W'(sap_pkg::QUEUE_DEPTH)) || sweeping;
  assign take     = in_valid && !in_stall;

  // classify the incoming word; unused command is swallowed
  always_comb begin
    kind = sap_pkg::KIND_MID;
    push = 1'b0;
    unique case (in_cmd)
      sap_pkg::CMD_MID: begin
        kind = sap_pkg::KIND_MID;
        push = take;
      end
      sap_pkg::CMD_SIDE: begin
        kind = sap_pkg::KIND_SIDE;
        push = take;
      end
      sap_pkg::CMD_CLEAR: begin
        kind = sap_pkg::KIND_CLEAR;
        push = take;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign bin_wide          = sap_pkg::CMP_W'(in_bin_index);
  assign new_item.kind     = kind;
  assign new_item.in_range = bin_wide < sap_pkg::CMP_W'(sap_pkg::NUM_BINS);
  assign new_item.addr     = bin_wide[sap_pkg::ADDR_W-1:0];
  assign new_item.bin      = in_bin_index;
  assign new_item.level    = in_level_db;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sap_pkg::QPTR_W'(sap_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sap_pkg::QPTR_W'(sap_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

endmodule

### rtl/sap_back.sv
module sap_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sap_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  input  sap_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         sweeping,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sap_pkg::LEVEL_W-1:0]  out_average_out,
  output logic [sap_pkg::LEVEL_W-1:0]  out_peak_out,
  output logic [sap_pkg::BIN_W-1:0]    out_bin_out,
  output logic                         out_is_side
);

  sap_pkg::back_state_t               state_r, state_nxt;
  sap_pkg::item_t                     cur_r;
  logic [sap_pkg::ADDR_W-1:0]         sweep_cnt_r, sweep_cnt_nxt;
  logic [sap_pkg::LEVEL_W-1:0]        sweep_val_r, sweep_val_nxt;
  logic signed [sap_pkg::PROD_W-1:0]  prod_r;
  logic [sap_pkg::LEVEL_W-1:0]        drop_r;
  logic [sap_pkg::LEVEL_W-1:0]        avg_r;

  logic                               out_valid_r, out_valid_nxt;
  logic [sap_pkg::LEVEL_W-1:0]        out_avg_r, out_peak_r;
  logic [sap_pkg::BIN_W-1:0]          out_bin_r;
  logic                               out_side_r;

  logic                               out_free;
  logic                               out_load;
  logic [sap_pkg::LEVEL_W-1:0]        ld_avg, ld_peak;
  logic [sap_pkg::BIN_W-1:0]          ld_bin;
  logic                               ld_side;

  logic                               rd_en;
  logic                               mid_we, side_we;
  logic [sap_pkg::ADDR_W-1:0]         waddr;
  logic [sap_pkg::LEVEL_W-1:0]        mid_wdata, peak_wdata, side_wdata;
  logic [sap_pkg::LEVEL_W-1:0]        mid_rd, peak_rd, side_rd;

  logic [sap_pkg::LEVEL_W-1:0]        avg_sel;
  logic signed [16:0]                 diff;
  logic signed [16:0]                 alpha_s;
  logic signed [sap_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [16:0]                 drop_full;
  logic [sap_pkg::LEVEL_W-1:0]        drop_nxt;
  logic signed [sap_pkg::PROD_W-1:0]  rnd;
  logic signed [17:0]                 delta;
  logic signed [18:0]                 avg_sum;
  logic [sap_pkg::LEVEL_W-1:0]        avg_new;
  logic [sap_pkg::LEVEL_W-1:0]        peak_new;
  logic                               is_side_cur;

  // ---------------- stores ----------------
  sap_ram #(.WIDTH(sap_pkg::LEVEL_W), .DEPTH(sap_pkg::NUM_BINS)) u_mid_ram (
    .clk   (clk),
    .we    (mid_we),
    .waddr (waddr),
    .wdata (mid_wdata),
    .re    (rd_en),
    .raddr (q_item.addr),
    .rdata (mid_rd)
  );

  sap_ram #(.WIDTH(sap_pkg::LEVEL_W), .DEPTH(sap_pkg::NUM_BINS)) u_peak_ram (
    .clk   (clk),
    .we    (mid_we),
    .waddr (waddr),
    .wdata (peak_wdata),
    .re    (rd_en),
    .raddr (q_item.addr),
    .rdata (peak_rd)
  );

  sap_ram #(.WIDTH(sap_pkg::LEVEL_W), .DEPTH(sap_pkg::NUM_BINS)) u_side_ram (
    .clk   (clk),
    .we    (side_we),
    .waddr (waddr),
    .wdata (side_wdata),
    .re    (rd_en),
    .raddr (q_item.addr),
    .rdata (side_rd)
  );

  // ---------------- datapath ----------------
  assign is_side_cur = (cur_r.kind == sap_pkg::KIND_SIDE);
  assign avg_sel     = is_side_cur ? side_rd : mid_rd;
  assign diff        = $signed({cur_r.level[15], cur_r.level}) -
                       $signed({avg_sel[15], avg_sel});
  assign alpha_s     = $signed({1'b0, cfg.alpha});
  assign prod_nxt    = diff * alpha_s;

  // peak minus decay, pinned at the most negative level
  assign drop_full   = $signed({peak_rd[15], peak_rd}) - $signed({2'b00, cfg.decay});
  assign drop_nxt    = (drop_full[16] != drop_full[15]) ? 16'h8000 : drop_full[15:0];

  // round half up, then floor shift
  assign rnd     = prod_r + sap_pkg::PROD_W'(32768);
  assign delta   = rnd[33:16];
  assign avg_sum = $signed({{3{avg_r[15]}}, avg_r}) + $signed({delta[17], delta});
  always_comb begin
    if (avg_sum[18:15] == 4'b0000 || avg_sum[18:15] == 4'b1111) begin
      avg_new = avg_sum[15:0];
    end else if (avg_sum[18]) begin
      avg_new = 16'h8000;
    end else begin
      avg_new = 16'h7fff;
    end
  end

  assign peak_new = ($signed(cur_r.level) > $signed(drop_r)) ? cur_r.level : drop_r;

  assign out_free = !out_valid_r || !out_stall;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sap_pkg::ST_SWEEP: begin
        if (sweep_cnt_r == sap_pkg::ADDR_W'(sap_pkg::NUM_BINS - 1)) begin
          state_nxt = sap_pkg::ST_IDLE;
        end
      end
      sap_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == sap_pkg::KIND_CLEAR) begin
            if (out_free) begin
              state_nxt = sap_pkg::ST_SWEEP;
            end
          end else if (q_item.in_range) begin
            state_nxt = sap_pkg::ST_MUL;
          end
        end
      end
      sap_pkg::ST_MUL: begin
        state_nxt = sap_pkg::ST_WB;
      end
      sap_pkg::ST_WB: begin
        if (out_free) begin
          state_nxt = sap_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sap_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    mid_we        = 1'b0;
    side_we       = 1'b0;
    waddr         = cur_r.addr;
    mid_wdata     = avg_new;
    peak_wdata    = peak_new;
    side_wdata    = avg_new;
    out_load      = 1'b0;
    ld_avg        = cfg.floor_lvl;
    ld_peak       = cfg.floor_lvl;
    ld_bin        = q_item.bin;
    ld_side       = 1'b0;
    sweep_cnt_nxt = sweep_cnt_r;
    sweep_val_nxt = sweep_val_r;
    unique case (state_r)
      sap_pkg::ST_SWEEP: begin
        mid_we        = 1'b1;
        side_we       = 1'b1;
        waddr         = sweep_cnt_r;
        mid_wdata     = sweep_val_r;
        peak_wdata    = sweep_val_r;
        side_wdata    = sweep_val_r;
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
      end
      sap_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == sap_pkg::KIND_CLEAR) begin
            if (out_free) begin
              q_pop         = 1'b1;
              out_load      = 1'b1;
              sweep_cnt_nxt = '0;
              sweep_val_nxt = cfg.floor_lvl;
            end
          end else if (!q_item.in_range) begin
            if (out_free) begin
              q_pop    = 1'b1;
              out_load = 1'b1;
              ld_side  = (q_item.kind == sap_pkg::KIND_SIDE);
            end
          end else begin
            q_pop = 1'b1;
            rd_en = 1'b1;
          end
        end
      end
      sap_pkg::ST_MUL: begin
      end
      sap_pkg::ST_WB: begin
        ld_bin  = cur_r.bin;
        ld_side = is_side_cur;
        ld_avg  = avg_new;
        ld_peak = is_side_cur ? cfg.floor_lvl : peak_new;
        if (out_free) begin
          out_load = 1'b1;
          mid_we   = !is_side_cur;
          side_we  = is_side_cur;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sap_pkg::ST_SWEEP;
      sweep_cnt_r <= '0;
      sweep_val_r <= sap_pkg::FLOOR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      sweep_val_r <= sweep_val_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r <= q_item;
    end
    if (state_r == sap_pkg::ST_MUL) begin
      prod_r <= prod_nxt;
      drop_r <= drop_nxt;
      avg_r  <= avg_sel;
    end
    if (out_load) begin
      out_avg_r  <= ld_avg;
      out_peak_r <= ld_peak;
      out_bin_r  <= ld_bin;
      out_side_r <= ld_side;
    end
  end

  assign sweeping        = (state_r == sap_pkg::ST_SWEEP);
  assign out_valid       = out_valid_r;
  assign out_average_out = out_avg_r;
  assign out_peak_out    = out_peak_r;
  assign out_bin_out     = out_bin_r;
  assign out_is_side     = out_side_r;

  // ---------------- checks ----------------
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == sap_pkg::ST_IDLE))
    else $error("queue popped outside idle");

  a_mul_then_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sap_pkg::ST_MUL) |=> (state_r == sap_pkg::ST_WB))
    else $error("multiply step not followed by write-back");

  a_sweep_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sap_pkg::ST_SWEEP) |-> (mid_we && side_we && !out_load))
    else $error("sweep cycle without store fill");

  a_wb_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sap_pkg::ST_WB && !out_free) |=> (state_r == sap_pkg::ST_WB))
    else $error("write-back left while output held");

endmodule

### rtl/spectrum_average_peak_hold_top.sv
// Flow: an update word goes from the queue through the read, multiply and write-back steps;
//   out-of-range and clear words go from the queue straight to the output register.
// The back end starts no new word until the last one is written back, over the dual-port
//   bin stores (separate read and write ports); clear adds a fill pass over all NUM_BINS bins.
// Reset (rst_n low, synchronous): registers to defaults, then a fill pass over every bin writes
//   the reset floor into all three stores; in_stall stays high during any fill pass.
module spectrum_average_peak_hold_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sap_pkg::CMD_W-1:0]       in_cmd,
  input  logic [sap_pkg::BIN_W-1:0]       in_bin_index,
  input  logic [sap_pkg::LEVEL_W-1:0]     in_level_db,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sap_pkg::LEVEL_W-1:0]     out_average_out,
  output logic [sap_pkg::LEVEL_W-1:0]     out_peak_out,
  output logic [sap_pkg::BIN_W-1:0]       out_bin_out,
  output logic                            out_is_side,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sap_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Config registers. The floor reaches the stores only at the next clear; the back end latches
  // it when it starts that pass. Clear, out-of-range and side-peak outputs use it at once.
  logic [sap_pkg::ALPHA_W-1:0]  alpha_r, alpha_nxt;
  logic [sap_pkg::DECAY_W-1:0]  decay_r, decay_nxt;
  logic [sap_pkg::LEVEL_W-1:0]  floor_r, floor_nxt;
  sap_pkg::cfg_t                cfg;

  // Front-to-back queue handshake
  logic                         q_valid;
  sap_pkg::item_t               q_item;
  logic                         q_pop;
  logic                         sweeping;

  // register index decode; unknown indexes are dropped
  always_comb begin
    alpha_nxt = alpha_r;
    decay_nxt = decay_r;
    floor_nxt = floor_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sap_pkg::CFG_ALPHA: alpha_nxt = cfg_data[sap_pkg::ALPHA_W-1:0];
        sap_pkg::CFG_DECAY: decay_nxt = cfg_data[sap_pkg::DECAY_W-1:0];
        sap_pkg::CFG_FLOOR: floor_nxt = cfg_data[sap_pkg::LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= sap_pkg::ALPHA_RESET;
      decay_r <= sap_pkg::DECAY_RESET;
      floor_r <= sap_pkg::FLOOR_RESET;
    end else begin
      alpha_r <= alpha_nxt;
      decay_r <= decay_nxt;
      floor_r <= floor_nxt;
    end
  end

  assign cfg.alpha     = alpha_r;
  assign cfg.decay     = decay_r;
  assign cfg.floor_lvl = floor_r;

  // Front: takes words, decodes the command, range-checks the bin and queues the word.
  // A word with the unused command code is taken and dropped.
  sap_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_bin_index (in_bin_index),
    .in_level_db  (in_level_db),
    .sweeping     (sweeping),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // Back: read-modify-write of the bin stores, fill passes, and the output register
  // that lets a finished word wait while the next one is worked on.
  sap_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .sweeping        (sweeping),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average_out (out_average_out),
    .out_peak_out    (out_peak_out),
    .out_bin_out     (out_bin_out),
    .out_is_side     (out_is_side)
  );

endmodule

### test/tb_spectrum_average_peak_hold_top.sv
`timescale 1ns / 1ps

module tb_spectrum_average_peak_hold_top;
  import sap_pkg::*;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'h7FFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 16'h8000;

  // Quiet cycles allowed with no word moving on either side. The slowest legal
  // quiet stretch is a full fill pass plus the idle wait before a register
  // write, the long receiver hold-off and the largest random gaps.
  localparam int WATCHDOG_LIMIT = 8 * NUM_BINS + 4000;
  // outlasts the fill pass of the phase's opening clear, so the queue backs up
  localparam int LONG_HOLD      = NUM_BINS + 400;
  localparam int FILL_WAIT      = NUM_BINS + 32;
  localparam int TAIL_WAIT      = 64;
  localparam int MAX_REPORTS    = 200;
  localparam int PHASE_WORDS    = 90;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd       = CMD_NONE;
  logic [BIN_W-1:0]      in_bin_index = '0;
  logic [LEVEL_W-1:0]    in_level_db  = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [LEVEL_W-1:0]    out_average_out;
  logic [LEVEL_W-1:0]    out_peak_out;
  logic [BIN_W-1:0]      out_bin_out;
  logic                  out_is_side;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Shared knobs between the stimulus and the result sink.
  bit no_idle          = 1'b0;  // both sides run back to back
  bit hold_off_request = 1'b0;  // sink does one long stall on its next word

  int unsigned quiet_cycles = 0;

  spectrum_average_peak_hold_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_bin_index    (in_bin_index),
    .in_level_db     (in_level_db),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average_out (out_average_out),
    .out_peak_out    (out_peak_out),
    .out_bin_out     (out_bin_out),
    .out_is_side     (out_is_side),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One result word as the block should present it.
  typedef struct {
    logic signed [LEVEL_W-1:0] average;
    logic signed [LEVEL_W-1:0] peak;
    logic [BIN_W-1:0]          bin;
    logic                      side;
  } bin_result_t;

  // Per-bin average / peak-hold tracker plus the queue of result words owed.
  class spectrum_tracker;
    logic signed [LEVEL_W-1:0] mid_avg   [NUM_BINS];
    logic signed [LEVEL_W-1:0] peak_hold [NUM_BINS];
    logic signed [LEVEL_W-1:0] side_avg  [NUM_BINS];
    logic [ALPHA_W-1:0]        alpha;
    logic [DECAY_W-1:0]        decay;
    logic signed [LEVEL_W-1:0] floor_db;
    bin_result_t               owed_words[$];
    int unsigned               fails;

    function void power_on();
      alpha    = ALPHA_RESET;
      decay    = DECAY_RESET;
      floor_db = FLOOR_RESET;
      fails    = 0;
      fill_stores(FLOOR_RESET);
    endfunction

    function void fill_stores(logic signed [LEVEL_W-1:0] v);
      for (int i = 0; i < NUM_BINS; i++) begin
        mid_avg[i]   = v;
        peak_hold[i] = v;
        side_avg[i]  = v;
      end
    endfunction

    function logic signed [LEVEL_W-1:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[LEVEL_W-1:0];
    endfunction

    // avg + round((level - avg) * alpha / 2^16), ties toward +inf
    function logic signed [LEVEL_W-1:0] ema_step(logic signed [LEVEL_W-1:0] avg,
                                                 logic signed [LEVEL_W-1:0] level);
      longint prod;
      prod = (longint'(level) - longint'(avg)) * longint'(alpha) + 32768;
      return clamp16(longint'(avg) + (prod >>> 16));
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ALPHA: alpha    = data;
        CFG_DECAY: decay    = data[DECAY_W-1:0];
        CFG_FLOOR: floor_db = data;
        default:   ;
      endcase
    endfunction

    // Called on every accepted input word.
    function void take_bin_word(logic [CMD_W-1:0] cmd, logic [BIN_W-1:0] bin,
                                logic signed [LEVEL_W-1:0] level);
      bin_result_t               w;
      logic signed [LEVEL_W-1:0] dropped;
      if (cmd == CMD_NONE) return;
      w.average = floor_db;
      w.peak    = floor_db;
      w.bin     = bin;
      w.side    = 1'b0;
      // An 11-bit index always lands inside the 2048-bin stores.
      case (cmd)
        CMD_CLEAR: fill_stores(floor_db);
        CMD_SIDE: begin
          w.side        = 1'b1;
          side_avg[bin] = ema_step(side_avg[bin], level);
          w.average     = side_avg[bin];
        end
        default: begin
          dropped        = clamp16(longint'(peak_hold[bin]) - longint'(decay));
          mid_avg[bin]   = ema_step(mid_avg[bin], level);
          peak_hold[bin] = (level > dropped) ? level : dropped;
          w.average      = mid_avg[bin];
          w.peak         = peak_hold[bin];
        end
      endcase
      owed_words.push_back(w);
    endfunction

    function void flag_field(string field, longint want, longint got);
      fails++;
      if (fails <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result_word(logic [LEVEL_W-1:0] avg, logic [LEVEL_W-1:0] peak,
                                    logic [BIN_W-1:0] bin, logic side);
      bin_result_t w;
      if (owed_words.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $error("unexpected result word: average %0d peak %0d bin %0d side %0b",
                 $signed(avg), $signed(peak), bin, side);
        return;
      end
      w = owed_words.pop_front();
      if (avg !== w.average) flag_field("average_out", w.average, $signed(avg));
      if (peak !== w.peak)   flag_field("peak_out", w.peak, $signed(peak));
      if (bin !== w.bin)     flag_field("bin_out", w.bin, bin);
      if (side !== w.side)   flag_field("is_side", w.side, side);
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  spectrum_tracker tracker = new();

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word after a random gap; returns at the edge that accepts it.
  // valid is only lowered when a gap is drawn, so a back-to-back word never
  // sees valid dropped and raised in the same step.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BIN_W-1:0] bin,
                           input logic [LEVEL_W-1:0] level);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd       <= cmd;
    in_bin_index <= bin;
    in_level_db  <= level;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.take_bin_word(cmd, bin, level);
  endtask

  // Random word. Most traffic hits a few hot bins so averages and peaks build
  // long histories; the rest sweeps the edges and the full index range.
  // counted is low for the unused command, which the block just drops.
  task automatic send_random_word(output bit counted);
    logic [CMD_W-1:0]   cmd;
    logic [BIN_W-1:0]   bin;
    logic [LEVEL_W-1:0] level;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      cmd = CMD_MID;
    else if (pick < 92) cmd = CMD_SIDE;
    else if (pick < 98) cmd = CMD_NONE;
    else                cmd = CMD_CLEAR;  // rare: each one costs a full fill pass
    pick = $urandom_range(0, 99);
    if (pick < 60)      bin = BIN_W'($urandom_range(0, 7));
    else if (pick < 70) bin = BIN_W'(NUM_BINS - 1 - $urandom_range(0, 3));
    else                bin = BIN_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10)      level = LEVEL_MAX;
    else if (pick < 20) level = LEVEL_MIN;
    else if (pick < 35) level = LEVEL_W'(int'(tracker.floor_db) + int'($urandom_range(0, 511)) - 256);
    else if (pick < 50) level = LEVEL_W'(int'($urandom_range(0, 1023)) - 512);
    else                level = LEVEL_W'($urandom);
    send_word(cmd, bin, level);
    counted = (cmd != CMD_NONE);
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // A clear can leave the back end busy (fill pass) after the last result;
  // give it the full fill time before touching registers.
  task automatic wait_fill_pass();
    repeat (FILL_WAIT) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it once after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] alpha,
                                input logic [CFG_DATA_W-1:0] decay,
                                input logic [CFG_DATA_W-1:0] floor_db,
                                input bit poke_unused);
    write_register(CFG_ALPHA, alpha);
    write_register(CFG_DECAY, decay);
    write_register(CFG_FLOOR, floor_db);
    if (poke_unused) write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // One settings phase: sender pauses until every result is back, block goes
  // idle, registers change, then random traffic. Without clear_first the old
  // floor stays in the stores, which checks that a floor write alone does not
  // refill them.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] alpha,
                           input logic [CFG_DATA_W-1:0] decay,
                           input logic [CFG_DATA_W-1:0] floor_db,
                           input bit poke_unused, input bit clear_first);
    int words;
    bit counted;
    in_valid <= 1'b0;
    wait_drained();
    wait_fill_pass();
    apply_settings(alpha, decay, floor_db, poke_unused);
    words = 0;
    if (clear_first) begin
      send_word(CMD_CLEAR, BIN_W'($urandom), LEVEL_W'($urandom));
      words++;
    end
    while (words < PHASE_WORDS) begin
      send_random_word(counted);
      if (counted) words++;
    end
  endtask

  initial begin : stimulus
    tracker.power_on();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // reset kicks off a fill pass; stay clear of it before the first writes
    wait_fill_pass();

    // Directed words under reset settings.
    send_word(CMD_MID,  11'd0,    LEVEL_MAX);
    send_word(CMD_MID,  11'd0,    LEVEL_MAX);
    send_word(CMD_MID,  11'd0,    LEVEL_MIN);   // peak decays, average turns down
    send_word(CMD_MID,  11'd2047, LEVEL_MIN);   // top bin, peak decays below floor
    send_word(CMD_SIDE, 11'd0,    LEVEL_MAX);   // side store independent of mid
    send_word(CMD_SIDE, 11'd2047, LEVEL_MIN);
    send_word(CMD_SIDE, 11'd0,    LEVEL_MIN);
    send_word(CMD_NONE, 11'd5,    16'h1234);    // unused command: no word, no update
    send_word(CMD_MID,  11'd5,    16'h1234);
    send_word(CMD_MID,  11'h555,  16'h5555);
    send_word(CMD_SIDE, 11'h2AA,  16'hAAAA);
    send_word(CMD_MID,  11'h2AA,  16'hAAAA);
    send_word(CMD_CLEAR, 11'h7FF, LEVEL_MAX);   // clear echoes the bin, floor out
    send_word(CMD_MID,  11'd0,    16'h0000);
    send_word(CMD_SIDE, 11'd0,    16'h0000);
    send_word(CMD_MID,  11'd5,    16'h1234);
    // rounding ties at alpha 1/4: +2 step rounds up, -2 step rounds to zero
    send_word(CMD_MID,  11'd9,    16'h8802);
    send_word(CMD_SIDE, 11'd9,    16'h87FE);
    send_word(CMD_MID,  11'd10,   FLOOR_RESET); // level equal to the floor
    send_word(CMD_NONE, 11'h7FF,  LEVEL_MIN);

    // Extremes low: frozen average, no peak decay, lowest floor.
    run_phase(16'd0, 16'd0, LEVEL_MIN, 1'b0, 1'b1);

    // Extremes high: full-step average, largest decay (peak saturates at the
    // bottom), floor at 0 dB. The sink holds off long while words keep coming.
    hold_off_request = 1'b1;
    run_phase(16'hFFFF, 16'h7FFF, 16'h0000, 1'b1, 1'b1);

    // Smallest nonzero steps, back to back on both sides, floor changed
    // without a clear.
    no_idle = 1'b1;
    run_phase(16'd1, 16'd1, 16'hFFFF, 1'b0, 1'b0);
    no_idle = 1'b0;

    // Random settings; decay writes carry a random top bit the block must drop.
    repeat (4) begin
      run_phase(CFG_DATA_W'($urandom),
                {1'($urandom), DECAY_W'($urandom_range(0, 32767))},
                CFG_DATA_W'(-int'($urandom_range(0, 32768))),
                1'($urandom), 1'($urandom));
    end

    run_phase(ALPHA_RESET, {1'b0, DECAY_RESET}, FLOOR_RESET, 1'b1, 1'b1);

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("spectrum_average_peak_hold_top regression: pass");
    end else begin
      $display("spectrum_average_peak_hold_top regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall before each word, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold             = LONG_HOLD;
        hold_off_request = 1'b0;
      end else if (no_idle) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 8);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      tracker.check_result_word(out_average_out, out_peak_out, out_bin_out, out_is_side);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no word moving on either side for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("spectrum_average_peak_hold_top regression: fail");
      $finish;
    end
  end

endmodule

### spectrum_average_peak_hold_top.f
rtl/sap_pkg.sv
rtl/sap_ram.sv
rtl/sap_front.sv
rtl/sap_back.sv
rtl/spectrum_average_peak_hold_top.sv
test/tb_spectrum_average_peak_hold_top.sv
